@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL of this project.
// Each macro expects a signal named clk in the enclosing module; ASSERT_RST also expects rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising clock edge outside reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ design/cfb_pkg.sv @@
package cfb_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ENTRY_COUNT      = 2'd0,
    REG_GREEN_LIMIT      = 2'd1,
    REG_FREE_GREEN_LIMIT = 2'd2,
    REG_RED_LIMIT        = 2'd3
  } reg_index_t;

  // Colour codes of an input entry.
  localparam logic [2:0] COL_OFF          = 3'd0;
  localparam logic [2:0] COL_GREEN        = 3'd1;
  localparam logic [2:0] COL_RED          = 3'd2;
  localparam logic [2:0] COL_YELLOW       = 3'd3;
  localparam logic [2:0] COL_GREEN_BLINK  = 3'd4;
  localparam logic [2:0] COL_YELLOW_BLINK = 3'd5;

  // Colour field of the tag byte.
  localparam logic [1:0] TAG_OFF    = 2'd0;
  localparam logic [1:0] TAG_GREEN  = 2'd1;
  localparam logic [1:0] TAG_YELLOW = 2'd2;
  localparam logic [1:0] TAG_RED    = 2'd3;

  // Frame header bytes.
  localparam logic [7:0] SYNC_BYTE0 = 8'h55;
  localparam logic [7:0] SYNC_BYTE1 = 8'hAA;

  // Most bytes one entry can produce.
  localparam int unsigned MAX_BYTES = 6;

  typedef logic [7:0] byte_t;

endpackage

@@ design/countdown_frame_builder_core.sv @@
// Countdown display frame builder.
// Input stream: one beat per configured countdown entry. s_tdata carries
// device_id, remaining_time and colour; s_tuser marks the first entry of a
// frame and s_tlast the last one. Output stream: one frame byte per beat on
// m_tdata, with m_tlast high on the checksum byte that closes a frame.
// A first entry yields 0x55, 0xAA and the entry count ahead of its tag and
// time bytes; a last entry is followed by the XOR checksum byte.
// An entry is held in the input register and computed combinationally from
// there into a six-byte result buffer, which then drains one byte per cycle
// while m_tready is high; an entry yields 2 to 6 bytes. The input register
// takes the next entry while the buffer still drains. Reset clears the
// configuration registers, the running checksum and all valid state;
// nothing is offered until a new entry arrives. When the receiver stalls,
// the current byte holds on m_tdata, the buffer stops and, once the input
// register is also full, s_tready drops. Configuration is written through
// cfg_wen/cfg_index/cfg_wdata by the user, who must do so only while idle;
// the block itself does not enforce it.
`include "assert_macros.svh"

module countdown_frame_builder_core #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  // Entry input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [4:0] device_id, [12:5] remaining_time, [15:13] colour
  input  logic        s_tuser,  // [0] first_entry
  input  logic        s_tlast,
  // Frame byte output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // [7:0] frame_byte
  output logic        m_tlast
);

  localparam logic [5:0] MAX_COUNT = 6'(MAX_ENTRIES);

  // Configuration registers.
  logic [5:0] entry_count;
  logic [7:0] green_limit;
  logic [7:0] free_green_limit;
  logic [7:0] red_limit;

  // Input register.
  logic       in_vld;
  logic [4:0] in_id;
  logic [7:0] in_time;
  logic [2:0] in_col;
  logic       in_first;
  logic       in_last;

  // Result buffer, drained from entry 0.
  cfb_pkg::byte_t buf_bytes [cfb_pkg::MAX_BYTES];
  cfb_pkg::byte_t buf_bytes_next [cfb_pkg::MAX_BYTES];
  logic [2:0]     buf_left;
  logic [2:0]     buf_left_next;
  logic           buf_end;

  logic [7:0] running_xor;
  logic [7:0] running_xor_next;

  logic       load;
  logic       out_beat;
  logic       blank;
  logic [7:0] eff_time;
  logic [1:0] tag_col;
  logic       tag_blink;
  logic [7:0] tag;
  logic [5:0] cnt;
  logic [7:0] chk;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count      <= '0;
      green_limit      <= '0;
      free_green_limit <= '0;
      red_limit        <= '0;
    end else if (cfg_wen) begin
      case (cfb_pkg::reg_index_t'(cfg_index))
        cfb_pkg::REG_ENTRY_COUNT:      entry_count      <= cfg_wdata[5:0];
        cfb_pkg::REG_GREEN_LIMIT:      green_limit      <= cfg_wdata;
        cfb_pkg::REG_FREE_GREEN_LIMIT: free_green_limit <= cfg_wdata;
        cfb_pkg::REG_RED_LIMIT:        red_limit        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: the buffer loads when empty or when its last byte leaves.
  assign out_beat = m_tvalid && m_tready;
  assign load     = in_vld && ((buf_left == 3'd0) || ((buf_left == 3'd1) && m_tready));
  assign s_tready = !in_vld || load;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_vld <= 1'b1;
    end else if (load) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_id    <= s_tdata[4:0];
      in_time  <= s_tdata[12:5];
      in_col   <= s_tdata[15:13];
      in_first <= s_tuser;
      in_last  <= s_tlast;
    end
  end

  // Limit rules: over-long green or red phases are sent as off with time 0.
  always_comb begin
    blank = 1'b0;
    if ((green_limit != 8'd0) && (in_col inside {cfb_pkg::COL_GREEN, cfb_pkg::COL_GREEN_BLINK})
        && ((in_time > green_limit) || (in_time > free_green_limit))) begin
      blank = 1'b1;
    end
    if ((red_limit != 8'd0) && (in_col == cfb_pkg::COL_RED) && (in_time > red_limit)) begin
      blank = 1'b1;
    end
  end

  assign eff_time = blank ? 8'd0 : in_time;

  // Tag byte: colour code, blink flag and device id.
  always_comb begin
    tag_col   = cfb_pkg::TAG_OFF;
    tag_blink = 1'b0;
    if (!blank) begin
      case (in_col)
        cfb_pkg::COL_GREEN:        tag_col = cfb_pkg::TAG_GREEN;
        cfb_pkg::COL_RED:          tag_col = cfb_pkg::TAG_RED;
        cfb_pkg::COL_YELLOW:       tag_col = cfb_pkg::TAG_YELLOW;
        cfb_pkg::COL_GREEN_BLINK: begin
          tag_col   = cfb_pkg::TAG_GREEN;
          tag_blink = 1'b1;
        end
        cfb_pkg::COL_YELLOW_BLINK: begin
          tag_col   = cfb_pkg::TAG_YELLOW;
          tag_blink = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign tag = {in_id, tag_blink, tag_col};
  assign cnt = (entry_count > MAX_COUNT) ? MAX_COUNT : entry_count;
  assign chk = (in_first ? {2'b00, cnt} : running_xor) ^ tag ^ eff_time;
  assign running_xor_next = in_last ? 8'd0 : chk;

  // Next buffer contents: a fresh entry, or the current bytes shifted by one.
  always_comb begin
    for (int i = 0; i < cfb_pkg::MAX_BYTES; i++) begin
      buf_bytes_next[i] = buf_bytes[i];
    end
    buf_left_next = buf_left;
    if (load) begin
      if (in_first) begin
        buf_bytes_next[0] = cfb_pkg::SYNC_BYTE0;
        buf_bytes_next[1] = cfb_pkg::SYNC_BYTE1;
        buf_bytes_next[2] = {2'b00, cnt};
        buf_bytes_next[3] = tag;
        buf_bytes_next[4] = eff_time;
        buf_bytes_next[5] = chk;
        buf_left_next     = in_last ? 3'd6 : 3'd5;
      end else begin
        buf_bytes_next[0] = tag;
        buf_bytes_next[1] = eff_time;
        buf_bytes_next[2] = chk;
        buf_left_next     = in_last ? 3'd3 : 3'd2;
      end
    end else if (out_beat) begin
      for (int i = 0; i < cfb_pkg::MAX_BYTES - 1; i++) begin
        buf_bytes_next[i] = buf_bytes[i + 1];
      end
      buf_left_next = buf_left - 3'd1;
    end
  end

  // Result buffer and running checksum.
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_left    <= '0;
      buf_end     <= 1'b0;
      running_xor <= '0;
    end else begin
      buf_left <= buf_left_next;
      if (load) begin
        buf_end     <= in_last;
        running_xor <= running_xor_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    buf_bytes <= buf_bytes_next;
  end

  assign m_tvalid = (buf_left != 3'd0);
  assign m_tdata  = buf_bytes[0];
  assign m_tlast  = buf_end && (buf_left == 3'd1);

  // Checks.
  `ASSERT_ALWAYS(a_left_range, rst || (buf_left <= 3'd6), "result buffer count out of range")
  `ASSERT_RST(a_in_hold, in_vld && !load |=> in_vld, "input entry dropped before load")
  `ASSERT_RST(a_tlast_src, m_tvalid && m_tlast |-> buf_end, "tlast without closing entry")
  `ASSERT_RST(a_xor_clear, load && in_last |=> running_xor == 8'd0, "checksum not cleared")
  `ASSERT_RST(a_load_empty, load |-> !m_tvalid || (buf_left == 3'd1 && m_tready), "overwrite")

endmodule
